FILE: design/pcbd_pkg.sv
package pcbd_pkg;

   localparam int BYTE_W     = 8;
   localparam int SLOT_W     = 3;
   localparam int DATA_W     = 5;
   localparam int POS_W      = 16;
   localparam int MID_SHIFT  = 5;
   localparam int HIGH_SHIFT = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_W      = 48;

   // slot codes carried in bits 7:5 of a request byte
   localparam logic [SLOT_W-1:0] SLOT_DEF_LOW  = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_DEF_MID  = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_DEF_HIGH = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_DEF_ROT  = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_OFF_LOW  = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_OFF_MID  = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_OFF_HIGH = 3'd6;
   localparam logic [SLOT_W-1:0] SLOT_COMMAND  = 3'd7;

   // csr register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEFENSE_RANGE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFENSE_RANGE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WAIT_BYTE      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CALIBRATE_BYTE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PLAY_BYTE      = 3'd4;

   localparam logic [POS_W-1:0]  RANGE_RESET     = 16'd32767;
   localparam logic [BYTE_W-1:0] WAIT_RESET      = 8'd224;
   localparam logic [BYTE_W-1:0] CALIBRATE_RESET = 8'd225;
   localparam logic [BYTE_W-1:0] PLAY_RESET      = 8'd226;

   typedef enum logic [1:0] {
      MODE_WAIT      = 2'd0,
      MODE_CALIBRATE = 2'd1,
      MODE_PLAY      = 2'd2
   } mode_type;

   // which part of a position word this byte supplies
   typedef struct packed {
      logic load;
      logic add_mid;
      logic add_high;
   } axis_ctrl_type;

   typedef struct packed {
      logic [POS_W-1:0] scratch;
      logic [POS_W-1:0] goal;
      logic             fault;
   } axis_next_type;

endpackage

FILE: design/pcbd_axis.sv
module pcbd_axis
   import pcbd_pkg::*;
(
   input  axis_ctrl_type     ctrl,
   input  logic [DATA_W-1:0] data,
   input  logic [POS_W-1:0]  scratch,
   input  logic [POS_W-1:0]  goal,
   input  logic [POS_W-1:0]  limit,
   output axis_next_type     nxt
);

   logic [POS_W-1:0] mid_term;
   logic [POS_W-1:0] high_term;
   logic [POS_W-1:0] sum;

   assign mid_term  = POS_W'({data, {MID_SHIFT{1'b0}}});
   assign high_term = POS_W'({data, {HIGH_SHIFT{1'b0}}});

   always_comb begin
      sum = scratch;
      if (ctrl.add_mid) begin
         sum = scratch + mid_term;
      end else if (ctrl.add_high) begin
         sum = scratch + high_term;
      end
   end

   always_comb begin
      nxt.scratch = scratch;
      nxt.goal    = goal;
      nxt.fault   = 1'b0;
      if (ctrl.load) begin
         nxt.scratch = POS_W'(data);
      end else if (ctrl.add_mid) begin
         nxt.scratch = sum;
      end else if (ctrl.add_high) begin
         // high word completes the position: accept or reject it
         nxt.scratch = sum;
         if (sum > limit) begin
            nxt.goal  = '0;
            nxt.fault = 1'b1;
         end else begin
            nxt.goal = sum;
         end
      end
   end

endmodule

FILE: design/position_command_byte_decoder_core.sv
// each request moves from the request register to the result register
// throughput: one request per cycle unless the result side stalls; the single
// update path between the two registers sets that rate, and a stalled result
// still lets one request enter
// reset: synchronous, active high; clears positions, rotations, mode to wait
// and restores the csr registers to their defaults
module position_command_byte_decoder_core
   import pcbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] defense_target, [31:16] offense_target, [36:32] defense_rotation,
   // [41:37] offense_rotation, [43:42] mode, [44] range_fault, [47:45] zero
   output logic [RSP_W-1:0]      rsp_tdata,
   // csr write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // csr registers
   logic [POS_W-1:0]  def_range_ff;
   logic [POS_W-1:0]  off_range_ff;
   logic [BYTE_W-1:0] wait_byte_ff;
   logic [BYTE_W-1:0] cal_byte_ff;
   logic [BYTE_W-1:0] play_byte_ff;

   // request register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // decoder state
   logic [POS_W-1:0]  def_scratch_ff;
   logic [POS_W-1:0]  off_scratch_ff;
   logic [POS_W-1:0]  def_goal_ff;
   logic [POS_W-1:0]  off_goal_ff;
   logic [DATA_W-1:0] def_rot_ff;
   logic [DATA_W-1:0] off_rot_ff;
   mode_type          mode_ff;

   logic [DATA_W-1:0] def_rot_in;
   logic [DATA_W-1:0] off_rot_in;
   mode_type          mode_in;

   // result register
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;
   logic [RSP_W-1:0]  rsp_data_in;

   logic              advance;
   logic              fire;
   logic [SLOT_W-1:0] slot;
   logic [DATA_W-1:0] data;
   axis_ctrl_type     def_ctrl;
   axis_ctrl_type     off_ctrl;
   axis_next_type     def_nxt;
   axis_next_type     off_nxt;
   logic              fault;

   // the result register frees up when empty or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign slot = in_byte_ff[BYTE_W-1 -: SLOT_W];
   assign data = in_byte_ff[DATA_W-1:0];

   // slot decode for the two position builders
   always_comb begin
      def_ctrl.load     = fire && (slot == SLOT_DEF_LOW);
      def_ctrl.add_mid  = fire && (slot == SLOT_DEF_MID);
      def_ctrl.add_high = fire && (slot == SLOT_DEF_HIGH);
      off_ctrl.load     = fire && (slot == SLOT_OFF_LOW);
      off_ctrl.add_mid  = fire && (slot == SLOT_OFF_MID);
      off_ctrl.add_high = fire && (slot == SLOT_OFF_HIGH);
   end

   pcbd_axis u_def_axis (
      .ctrl    (def_ctrl),
      .data    (data),
      .scratch (def_scratch_ff),
      .goal    (def_goal_ff),
      .limit   (def_range_ff),
      .nxt     (def_nxt)
   );

   pcbd_axis u_off_axis (
      .ctrl    (off_ctrl),
      .data    (data),
      .scratch (off_scratch_ff),
      .goal    (off_goal_ff),
      .limit   (off_range_ff),
      .nxt     (off_nxt)
   );

   assign fault = def_nxt.fault || off_nxt.fault;

   // rotations and mode
   always_comb begin
      def_rot_in = def_rot_ff;
      off_rot_in = off_rot_ff;
      mode_in    = mode_ff;
      if (fire) begin
         case (slot)
            SLOT_DEF_ROT: begin
               def_rot_in = data;
            end
            SLOT_COMMAND: begin
               // special bytes first, priority wait > calibrate > play
               if (in_byte_ff == wait_byte_ff) begin
                  mode_in = MODE_WAIT;
               end else if (in_byte_ff == cal_byte_ff) begin
                  mode_in = MODE_CALIBRATE;
               end else if (in_byte_ff == play_byte_ff) begin
                  mode_in = MODE_PLAY;
               end else begin
                  off_rot_in = data;
               end
            end
            default: begin
            end
         endcase
      end
      // a rejected position drops back to wait
      if (fault) begin
         mode_in = MODE_WAIT;
      end
   end

   assign rsp_data_in = {3'b000, fault, mode_in, off_rot_in, def_rot_in,
                         off_nxt.goal, def_nxt.goal};

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         def_range_ff <= RANGE_RESET;
         off_range_ff <= RANGE_RESET;
         wait_byte_ff <= WAIT_RESET;
         cal_byte_ff  <= CALIBRATE_RESET;
         play_byte_ff <= PLAY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DEFENSE_RANGE:  def_range_ff <= csr_wdata;
            REG_OFFENSE_RANGE:  off_range_ff <= csr_wdata;
            REG_WAIT_BYTE:      wait_byte_ff <= csr_wdata[BYTE_W-1:0];
            REG_CALIBRATE_BYTE: cal_byte_ff  <= csr_wdata[BYTE_W-1:0];
            REG_PLAY_BYTE:      play_byte_ff <= csr_wdata[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // decoder state, updated as each request moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         def_scratch_ff <= '0;
         off_scratch_ff <= '0;
         def_goal_ff    <= '0;
         off_goal_ff    <= '0;
         def_rot_ff     <= '0;
         off_rot_ff     <= '0;
         mode_ff        <= MODE_WAIT;
      end else begin
         def_scratch_ff <= def_nxt.scratch;
         off_scratch_ff <= off_nxt.scratch;
         def_goal_ff    <= def_nxt.goal;
         off_goal_ff    <= off_nxt.goal;
         def_rot_ff     <= def_rot_in;
         off_rot_ff     <= off_rot_in;
         mode_ff        <= mode_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // a faulted result always reports wait mode
   a_fault_waits: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[44]) |-> (rsp_data_ff[43:42] == MODE_WAIT))
      else $error("range fault without wait mode");

   // a faulted result has a cleared target on one axis
   a_fault_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[44]) |->
         (rsp_data_ff[15:0] == '0 || rsp_data_ff[31:16] == '0))
      else $error("range fault kept a nonzero target");

   // a held request is never dropped while the result side stalls
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled request lost");

   // decoder state only changes when a request moves forward
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(def_goal_ff) && $stable(off_goal_ff) && $stable(mode_ff)))
      else $error("state changed without a request");
`endif

endmodule

FILE: sim/tb_position_command_byte_decoder_core.sv
module tb_position_command_byte_decoder_core
   import pcbd_pkg::*;
();

   // cycles with no handshake on either side before the run is abandoned
   localparam int STALL_LIMIT = 1000;
   // cycles to linger once the last expected status has arrived
   localparam int SETTLE_CYCLES = 8;

   // one result word, laid out as on rsp_tdata
   typedef struct packed {
      logic [2:0]        spare;
      logic              fault;
      logic [1:0]        mode;
      logic [DATA_W-1:0] off_rot;
      logic [DATA_W-1:0] def_rot;
      logic [POS_W-1:0]  off_target;
      logic [POS_W-1:0]  def_target;
   } status_type;

   // tracks the decoder state and the status words still owed by the block
   class decoder_scoreboard;
      logic [POS_W-1:0]  def_limit;
      logic [POS_W-1:0]  off_limit;
      logic [BYTE_W-1:0] wait_key;
      logic [BYTE_W-1:0] cal_key;
      logic [BYTE_W-1:0] play_key;
      logic [POS_W-1:0]  def_scratch;
      logic [POS_W-1:0]  off_scratch;
      logic [POS_W-1:0]  def_goal;
      logic [POS_W-1:0]  off_goal;
      logic [DATA_W-1:0] def_rot;
      logic [DATA_W-1:0] off_rot;
      mode_type          mode_now;
      status_type        pending_status[$];
      int                errors;
      int                shown;
      int                checked;
      int                faults;

      function new();
         def_limit      = RANGE_RESET;
         off_limit      = RANGE_RESET;
         wait_key       = WAIT_RESET;
         cal_key        = CALIBRATE_RESET;
         play_key       = PLAY_RESET;
         def_scratch    = '0;
         off_scratch    = '0;
         def_goal       = '0;
         off_goal       = '0;
         def_rot        = '0;
         off_rot        = '0;
         mode_now       = MODE_WAIT;
         errors         = 0;
         shown          = 0;
         checked        = 0;
         faults         = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_DEFENSE_RANGE:  def_limit = value;
            REG_OFFENSE_RANGE:  off_limit = value;
            REG_WAIT_BYTE:      wait_key = value[BYTE_W-1:0];
            REG_CALIBRATE_BYTE: cal_key = value[BYTE_W-1:0];
            REG_PLAY_BYTE:      play_key = value[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      // apply one accepted byte and queue the status it must produce
      function void note_request(logic [BYTE_W-1:0] rx);
         logic [POS_W-1:0] d;
         logic             fault;
         status_type       st;
         d     = POS_W'(rx[DATA_W-1:0]);
         fault = 1'b0;
         case (rx[BYTE_W-1:DATA_W])
            SLOT_DEF_LOW: def_scratch = d;
            SLOT_DEF_MID: def_scratch = def_scratch + (d << MID_SHIFT);
            SLOT_DEF_HIGH: begin
               def_scratch = def_scratch + (d << HIGH_SHIFT);
               if (def_scratch > def_limit) begin
                  def_goal = '0;
                  mode_now = MODE_WAIT;
                  fault    = 1'b1;
               end else begin
                  def_goal = def_scratch;
               end
            end
            SLOT_DEF_ROT: def_rot = rx[DATA_W-1:0];
            SLOT_OFF_LOW: off_scratch = d;
            SLOT_OFF_MID: off_scratch = off_scratch + (d << MID_SHIFT);
            SLOT_OFF_HIGH: begin
               off_scratch = off_scratch + (d << HIGH_SHIFT);
               if (off_scratch > off_limit) begin
                  off_goal = '0;
                  mode_now = MODE_WAIT;
                  fault    = 1'b1;
               end else begin
                  off_goal = off_scratch;
               end
            end
            default: begin
               // command slot: wait beats calibrate beats play
               if (rx == wait_key) mode_now = MODE_WAIT;
               else if (rx == cal_key) mode_now = MODE_CALIBRATE;
               else if (rx == play_key) mode_now = MODE_PLAY;
               else off_rot = rx[DATA_W-1:0];
            end
         endcase
         st            = '0;
         st.fault      = fault;
         st.mode       = mode_now;
         st.off_rot    = off_rot;
         st.def_rot    = def_rot;
         st.off_target = off_goal;
         st.def_target = def_goal;
         pending_status.push_back(st);
      endfunction

      function void check_result(logic [RSP_W-1:0] raw);
         status_type got;
         status_type want;
         got = raw;
         checked++;
         if (got.fault === 1'b1) faults++;
         if (pending_status.size() == 0) begin
            errors++;
            if (shown < 10) $display("unexpected status word %h with none pending", raw);
            shown++;
            return;
         end
         want = pending_status.pop_front();
         if (got.def_target !== want.def_target || got.off_target !== want.off_target ||
             got.def_rot !== want.def_rot || got.off_rot !== want.off_rot ||
             got.mode !== want.mode || got.fault !== want.fault ||
             got.spare !== want.spare) begin
            errors++;
            if (shown < 10) begin
               $display("status %0d mismatch: expected def %0d off %0d drot %0d orot %0d %s",
                        checked, want.def_target, want.off_target, want.def_rot,
                        want.off_rot, "");
               $display("   expected mode %0d fault %0b spare %0d", want.mode, want.fault,
                        want.spare);
               $display("   got def %0d off %0d drot %0d orot %0d", got.def_target,
                        got.off_target, got.def_rot, got.off_rot);
               $display("   got mode %0d fault %0b spare %0d", got.mode, got.fault,
                        got.spare);
            end
            shown++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;     // [7:0] rx_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] defense_target, [31:16] offense_target, [36:32] defense_rotation,
   // [41:37] offense_rotation, [43:42] mode, [44] range_fault, [47:45] zero
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   decoder_scoreboard sb;
   bit quiet = 1'b0;           // when set neither side idles
   int sent_bytes = 0;
   int settings_count = 0;
   int stalled_cycles = 0;

   position_command_byte_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // result side: random back-pressure, status check and the stall watchdog
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 23);
      // values read here are the ones present at this edge
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles == STALL_LIMIT) begin
         $display("[position_command_byte_decoder_core] ERROR");
         $finish;
      end
   end

   // offer one request byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [BYTE_W-1:0] rx);
      while (!quiet && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(rx);
      sent_bytes++;
   endtask

   // drop valid and wait until every owed status word has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.pending_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(idx, value);
   endtask

   // load all five registers; only called while the block is idle
   task automatic write_settings(input logic [POS_W-1:0] def_range,
                                 input logic [POS_W-1:0] off_range,
                                 input logic [BYTE_W-1:0] wait_val,
                                 input logic [BYTE_W-1:0] cal_val,
                                 input logic [BYTE_W-1:0] play_val);
      write_csr(REG_DEFENSE_RANGE, def_range);
      write_csr(REG_OFFENSE_RANGE, off_range);
      write_csr(REG_WAIT_BYTE, CSR_DATA_W'(wait_val));
      write_csr(REG_CALIBRATE_BYTE, CSR_DATA_W'(cal_val));
      write_csr(REG_PLAY_BYTE, CSR_DATA_W'(play_val));
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   // mostly complete low/mid/high position runs, plus rotations, commands and noise
   task automatic run_random(input int count);
      int   stop_at;
      int   pick;
      int   extra;
      logic axis;
      stop_at = sent_bytes + count;
      while (sent_bytes < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            axis = 1'($urandom_range(1));
            send_byte({axis ? SLOT_OFF_LOW : SLOT_DEF_LOW, 5'($urandom)});
            send_byte({axis ? SLOT_OFF_MID : SLOT_DEF_MID, 5'($urandom)});
            // now and then stack extra high adds so the scratch wraps
            extra = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
            repeat (extra) send_byte({axis ? SLOT_OFF_HIGH : SLOT_DEF_HIGH, 5'($urandom)});
            send_byte({axis ? SLOT_OFF_HIGH : SLOT_DEF_HIGH, 5'($urandom)});
         end else if (pick < 65) begin
            send_byte({$urandom_range(1) ? SLOT_DEF_ROT : SLOT_COMMAND, 5'($urandom)});
         end else if (pick < 80) begin
            case ($urandom_range(2))
               0:       send_byte(sb.wait_key);
               1:       send_byte(sb.cal_key);
               default: send_byte(sb.play_key);
            endcase
         end else begin
            send_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: boundary positions, wrap, every slot, every command
      send_byte({SLOT_DEF_LOW, 5'd31});
      send_byte({SLOT_DEF_MID, 5'd31});
      send_byte({SLOT_DEF_HIGH, 5'd31});      // exactly at the range limit
      send_byte({SLOT_DEF_LOW, 5'd0});
      send_byte({SLOT_DEF_MID, 5'd0});
      send_byte({SLOT_DEF_HIGH, 5'd0});
      send_byte({SLOT_DEF_ROT, 5'd31});
      send_byte({SLOT_DEF_ROT, 5'd0});
      send_byte({SLOT_COMMAND, 5'd2});         // play
      send_byte({SLOT_OFF_LOW, 5'd31});
      send_byte({SLOT_OFF_MID, 5'd31});
      send_byte({SLOT_OFF_HIGH, 5'd31});
      send_byte({SLOT_OFF_HIGH, 5'd1});        // past the limit, forces wait
      send_byte({SLOT_COMMAND, 5'd1});         // calibrate
      send_byte({SLOT_DEF_HIGH, 5'd31});
      send_byte({SLOT_DEF_HIGH, 5'd31});       // out of range
      send_byte({SLOT_DEF_HIGH, 5'd31});       // scratch wraps back into range
      send_byte({SLOT_COMMAND, 5'd3});         // plain offense rotation
      send_byte({SLOT_COMMAND, 5'd31});
      send_byte({SLOT_COMMAND, 5'd2});
      send_byte({SLOT_COMMAND, 5'd0});         // wait
      send_byte(8'h00);
      send_byte(8'hFF);
      run_random(250);

      // tightest ranges, specials at the top of the command slot
      wait_idle();
      write_settings(16'd0, 16'd0, 8'd255, 8'd254, 8'd253);
      run_random(250);

      // widest ranges, all specials equal so wait must win
      wait_idle();
      write_settings(16'hFFFF, 16'hFFFF, 8'd224, 8'd224, 8'd224);
      run_random(250);

      // calibrate and play share a code, calibrate must win
      wait_idle();
      write_settings(16'($urandom_range(32767)), 16'($urandom_range(32767)),
                     8'd230, 8'd240, 8'd240);
      run_random(250);

      // back-to-back traffic with no idling on either side
      quiet = 1'b1;
      wait_idle();
      write_settings(16'($urandom_range(36000)), 16'($urandom_range(36000)),
                     8'($urandom_range(255, 224)), 8'($urandom_range(255, 224)),
                     8'($urandom_range(255, 224)));
      run_random(250);
      quiet = 1'b0;

      wait_idle();
      write_settings(16'($urandom_range(36000)), 16'($urandom_range(36000)),
                     8'($urandom_range(255, 224)), 8'($urandom_range(255, 224)),
                     8'($urandom_range(255, 224)));
      run_random(250);

      // drain, then linger so a stray extra status word would be seen
      wait_idle();
      if (sb.pending_status.size() != 0) begin
         sb.errors += sb.pending_status.size();
         $display("%0d status words never arrived", sb.pending_status.size());
      end
      $display("sent %0d request bytes across %0d register settings", sent_bytes,
               settings_count);
      $display("checked %0d status words, %0d of them flagged a range fault", sb.checked,
               sb.faults);
      if (sb.errors == 0) begin
         $display("[position_command_byte_decoder_core] OK");
      end else begin
         $display("%0d mismatches in total", sb.errors);
         $display("[position_command_byte_decoder_core] ERROR");
      end
      $finish;
   end

endmodule
